// ===== rtl/core/gdha_pkg.sv =====
// shared types, constants and defaults of the gated dual histogram accumulator
`timescale 1ns / 1ps

package gdha_pkg;

  // default sizes
  localparam int CHANNELS_DEF = 64;
  localparam int BINS_DEF     = 32768;

  // overflow and underflow bin sits this far below the end of the histogram
  localparam int OUT_OFFSET = 4000;

  // fixed widths of the word fields
  localparam int FUNC_W      = 2;
  localparam int CH_PORT_W   = 6;
  localparam int BIN_PORT_W  = 15;
  localparam int VALUE_W     = 32;
  localparam int SCALE_W     = 24;
  localparam int COUNT_W     = 32;

  // Q27.4 times Q8.16 gives Q.20; one extra bit for the zero-extended scale
  localparam int FRAC_BITS   = 20;
  localparam int PROD_W      = VALUE_W + SCALE_W + 1;
  localparam int HALF_LSB    = 524288;

  // register port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  // register indexes, taken from paddr[2]
  localparam logic REG_TIME_SCALE   = 1'b0;
  localparam logic REG_ENERGY_SCALE = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_HIT         = 2'd0,
    FN_READ_ENERGY = 2'd1,
    FN_READ_TIME   = 2'd2,
    FN_LOAD_WINDOW = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WIN,
    ST_BIN,
    ST_RD,
    ST_WR,
    ST_RES
  } state_t;

  // histogram bank controls
  typedef struct packed {
    logic clr;
    logic rd;
    logic inc;
  } bank_ctl_t;

  // window store controls
  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } win_ctl_t;

endpackage

// ===== rtl/core/gdha_scale.sv =====
// two-stage scaling of a Q27.4 value to a histogram bin, rounded half up
`timescale 1ns / 1ps

module gdha_scale import gdha_pkg::*; #(
  parameter int BINS = BINS_DEF,
  localparam int BIN_W = $clog2(BINS)
) (
  input  logic                      clk,
  input  logic signed [VALUE_W-1:0] value,
  input  logic        [SCALE_W-1:0] scale,
  output logic        [BIN_W-1:0]   bin
);

  localparam int R_W = PROD_W - FRAC_BITS;
  localparam logic [BIN_W-1:0] OUT_BIN = BIN_W'(BINS - OUT_OFFSET);

  logic signed [SCALE_W:0]   scale_s;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  sum;
  logic        [R_W-1:0]     rounded;
  logic                      neg;
  logic        [BIN_W-1:0]   bin_next;

  // stage one: exact signed product
  assign scale_s   = $signed({1'b0, scale});
  assign prod_next = PROD_W'(value) * PROD_W'(scale_s);

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  // stage two: round half up, fold negatives and overflow into the spare bin
  assign sum     = prod + PROD_W'(HALF_LSB);
  assign rounded = sum[PROD_W-1:FRAC_BITS];
  assign neg     = prod[PROD_W-1];

  always_comb begin
    if (neg || (rounded >= R_W'(BINS))) begin
      bin_next = OUT_BIN;
    end else begin
      bin_next = rounded[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    bin <= bin_next;
  end

endmodule

// ===== rtl/core/gdha_window.sv =====
// per-channel time window store with registered read and open-interval check
`timescale 1ns / 1ps

module gdha_window import gdha_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int CH_W = $clog2(CHANNELS)
) (
  input  logic                      clk,
  input  win_ctl_t                  ctl,
  input  logic        [CH_W-1:0]    addr,
  input  logic signed [VALUE_W-1:0] low_in,
  input  logic signed [VALUE_W-1:0] high_in,
  input  logic signed [VALUE_W-1:0] probe,
  output logic                      in_window
);

  localparam logic [CH_W:0] CH_LIM = (CH_W+1)'(CHANNELS);

  logic signed [VALUE_W-1:0] lower_mem [CHANNELS];
  logic signed [VALUE_W-1:0] upper_mem [CHANNELS];
  logic signed [VALUE_W-1:0] lower_q;
  logic signed [VALUE_W-1:0] upper_q;
  logic                      addr_ok;

  assign addr_ok = {1'b0, addr} < CH_LIM;

  // write port: clearing pass or window load
  always_ff @(posedge clk) begin
    if ((ctl.clr || ctl.wr) && addr_ok) begin
      lower_mem[addr] <= ctl.clr ? '0 : low_in;
      upper_mem[addr] <= ctl.clr ? '0 : high_in;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (ctl.rd && addr_ok) begin
      lower_q <= lower_mem[addr];
      upper_q <= upper_mem[addr];
    end
  end

  // strictly inside the window
  assign in_window = (probe > lower_q) && (probe < upper_q);

endmodule

// ===== rtl/core/gdha_hist_bank.sv =====
// one histogram memory with read, saturating increment write-back and clear
`timescale 1ns / 1ps

module gdha_hist_bank import gdha_pkg::*; #(
  parameter int DEPTH = CHANNELS_DEF * BINS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  bank_ctl_t          ctl,
  input  logic [ADDR_W-1:0]  addr,
  output logic [COUNT_W-1:0] data
);

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]  addr_q;
  logic [COUNT_W-1:0] inc_val;

  // saturating increment of the word read last
  assign inc_val = (data == '1) ? data : data + COUNT_W'(1);

  // write port: clear at the given address, or write back to the read address
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[addr] <= '0;
    end else if (ctl.inc) begin
      mem[addr_q] <= inc_val;
    end
  end

  // read port, address kept for the write-back
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      addr_q <= addr;
      data   <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/gated_dual_histogram_accumulator.sv =====
// top level: register port, sequencer, item registers and result register
`timescale 1ns / 1ps

// Gated dual histogram accumulator. Each input word is a hit, a bin read or a
// window load, chosen by func. A hit on a nonzero channel with all three flags
// set and its time strictly inside the channel's window adds one, saturating,
// to one bin of that channel's energy histogram and one of its time histogram;
// both bins come from the value times its Q8.16 scale register, rounded half
// up, with negative or too large results sent to bin BINS-4000. The two
// histograms live in synchronous memories of CHANNELS*BINS words, each with
// one read and one write port, and every update is a read, an increment and
// a write-back; the sequencer handles one word at a time, so the next word's
// read can never meet a pending write. A counted hit passes window check with
// the multiply, bin rounding, memory read, write-back and idle before the next
// acceptance; a hit failing the gate returns to idle after the window check,
// a bin read passes memory read and the result state plus any wait for the
// result register to empty, and a window load stays in idle. After reset a
// clearing pass zeroes both histograms and the windows, one address per cycle
// over all CHANNELS*BINS addresses (2097152 at the default sizes) before the
// first word is taken; the scale registers can be written during that pass.

module gated_dual_histogram_accumulator import gdha_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int BINS     = BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [PDATA_W-1:0]           pwdata,
  output logic [PDATA_W-1:0]           prdata,
  output logic                         pready,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [FUNC_W-1:0]            func,
  input  logic [CH_PORT_W-1:0]         channel,
  input  logic                         event_has_hits,
  input  logic                         time_hit,
  input  logic                         energy_hit,
  input  logic signed [VALUE_W-1:0]    time_value,
  input  logic signed [VALUE_W-1:0]    energy_value,
  input  logic [BIN_PORT_W-1:0]        bin,
  input  logic signed [VALUE_W-1:0]    window_low,
  input  logic signed [VALUE_W-1:0]    window_high,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COUNT_W-1:0]           count
);

  localparam int DEPTH  = CHANNELS * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_W   = $clog2(CHANNELS);
  localparam int BIN_W  = $clog2(BINS);

  // configuration
  logic [SCALE_W-1:0] time_scale;
  logic [SCALE_W-1:0] energy_scale;
  logic               cfg_wr;

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               clr_last;
  logic               accept;
  logic               load_out;

  // input word decode
  func_t              in_func;
  logic               in_ch_ok;
  logic [CH_W-1:0]    in_ch_idx;

  // item registers
  func_t                     func_q;
  logic [CH_W-1:0]           ch_q;
  logic [BIN_PORT_W-1:0]     bin_q;
  logic signed [VALUE_W-1:0] time_q;
  logic signed [VALUE_W-1:0] energy_q;
  logic                      hit_gate_q;
  logic                      rd_ok_q;

  // datapath
  logic [BIN_W-1:0]   time_bin;
  logic [BIN_W-1:0]   energy_bin;
  logic               in_window;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  t_addr;
  logic [ADDR_W-1:0]  e_addr;
  logic [COUNT_W-1:0] t_data;
  logic [COUNT_W-1:0] e_data;
  logic [COUNT_W-1:0] count_next;
  logic [CH_W-1:0]    win_addr;
  bank_ctl_t          bank_ctl;
  win_ctl_t           win_ctl;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_scale   <= SCALE_RESET;
      energy_scale <= SCALE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TIME_SCALE:   time_scale   <= pwdata[SCALE_W-1:0];
        REG_ENERGY_SCALE: energy_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIME_SCALE:   prdata = PDATA_W'(time_scale);
      REG_ENERGY_SCALE: prdata = PDATA_W'(energy_scale);
      default:          prdata = '0;
    endcase
  end

  // input word decode
  assign accept    = in_valid && !in_stall;
  assign in_func   = func_t'(func);
  assign in_ch_ok  = {1'b0, channel} < (CH_PORT_W+1)'(CHANNELS);
  assign in_ch_idx = in_ch_ok ? channel[CH_W-1:0] : '0;

  // capture the word on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= in_func;
      ch_q       <= in_ch_idx;
      bin_q      <= bin;
      time_q     <= time_value;
      energy_q   <= energy_value;
      hit_gate_q <= in_ch_ok && (channel != '0) && event_has_hits && time_hit && energy_hit;
      rd_ok_q    <= in_ch_ok && (32'(bin) < 32'(BINS));
    end
  end

  // clearing pass counter
  assign clr_last = clr_cnt == ADDR_W'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_HIT:         state_next = ST_WIN;
            FN_READ_ENERGY: state_next = ST_RD;
            FN_READ_TIME:   state_next = ST_RD;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_WIN: begin
        state_next = (hit_gate_q && in_window) ? ST_BIN : ST_IDLE;
      end
      ST_BIN: begin
        state_next = ST_RD;
      end
      ST_RD: begin
        state_next = (func_q == FN_HIT) ? ST_WR : ST_RES;
      end
      ST_WR: begin
        state_next = ST_IDLE;
      end
      ST_RES: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = state != ST_IDLE;
    bank_ctl.clr  = state == ST_CLEAR;
    bank_ctl.rd   = (state == ST_RD) && ((func_q == FN_HIT) || rd_ok_q);
    bank_ctl.inc  = state == ST_WR;
    win_ctl.clr   = state == ST_CLEAR;
    win_ctl.rd    = accept;
    win_ctl.wr    = accept && (in_func == FN_LOAD_WINDOW) && in_ch_ok;
    load_out      = (state == ST_RES) && (!out_valid || !out_stall);
  end

  // window store
  assign win_addr = (state == ST_CLEAR) ? clr_cnt[CH_W-1:0] : in_ch_idx;

  gdha_window #(
    .CHANNELS (CHANNELS)
  ) u_window (
    .clk       (clk),
    .ctl       (win_ctl),
    .addr      (win_addr),
    .low_in    (window_low),
    .high_in   (window_high),
    .probe     (time_q),
    .in_window (in_window)
  );

  // bin computation for both histograms
  gdha_scale #(
    .BINS (BINS)
  ) u_time_scale (
    .clk   (clk),
    .value (time_q),
    .scale (time_scale),
    .bin   (time_bin)
  );

  gdha_scale #(
    .BINS (BINS)
  ) u_energy_scale (
    .clk   (clk),
    .value (energy_q),
    .scale (energy_scale),
    .bin   (energy_bin)
  );

  // histogram addresses: channel row plus bin
  assign base = ADDR_W'(ch_q) * ADDR_W'(BINS);

  always_comb begin
    if (state == ST_CLEAR) begin
      t_addr = clr_cnt;
      e_addr = clr_cnt;
    end else if (func_q == FN_HIT) begin
      t_addr = base + ADDR_W'(time_bin);
      e_addr = base + ADDR_W'(energy_bin);
    end else begin
      t_addr = base + ADDR_W'(bin_q);
      e_addr = base + ADDR_W'(bin_q);
    end
  end

  gdha_hist_bank #(
    .DEPTH (DEPTH)
  ) u_time_bank (
    .clk  (clk),
    .ctl  (bank_ctl),
    .addr (t_addr),
    .data (t_data)
  );

  gdha_hist_bank #(
    .DEPTH (DEPTH)
  ) u_energy_bank (
    .clk  (clk),
    .ctl  (bank_ctl),
    .addr (e_addr),
    .data (e_data)
  );

  // result register
  always_comb begin
    if (!rd_ok_q) begin
      count_next = '0;
    end else if (func_q == FN_READ_ENERGY) begin
      count_next = e_data;
    end else begin
      count_next = t_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      count <= count_next;
    end
  end

endmodule
